// ===== rtl/swsc_pkg.sv =====
// shared constants, codes and types for the sliding window symbol counter
package swsc_pkg;

  localparam int WINDOW_MAX_DEF = 1024;
  localparam int WIDTH_RESET    = 1024;

  localparam int OP_W    = 1;
  localparam int SYM_W   = 2;
  localparam int CFG_W   = 11;
  localparam int COUNT_W = 11;

  // s_tdata carries the symbol, m_tdata the three counts, both padded to bytes
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_ADVANCE = 1'b0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 1'b1;

  localparam logic [SYM_W-1:0] SYM_NONE    = 2'd0;
  localparam logic [SYM_W-1:0] SYM_READ    = 2'd1;
  localparam logic [SYM_W-1:0] SYM_WRITE   = 2'd2;
  localparam logic [SYM_W-1:0] SYM_INVALID = 2'd3;

  // one request as seen by the tally update
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] stale;
  } tally_req_t;

endpackage

// ===== rtl/swsc_tally.sv =====
// running read and write totals update and none count
module swsc_tally #(
  parameter int WINDOW_MAX = swsc_pkg::WINDOW_MAX_DEF,
  parameter int CW         = $clog2(WINDOW_MAX + 1)
) (
  input  swsc_pkg::tally_req_t req,
  input  logic [CW-1:0]        rd_total,
  input  logic [CW-1:0]        wr_total,
  input  logic [CW-1:0]        width,
  output logic [CW-1:0]        rd_total_next,
  output logic [CW-1:0]        wr_total_next,
  output logic [CW-1:0]        none_next
);
  import swsc_pkg::*;

  localparam logic [CW-1:0] TOTAL_MAX = CW'(WINDOW_MAX);

  logic [CW:0] sum;

  always_comb begin
    rd_total_next = rd_total;
    wr_total_next = wr_total;
    if (req.op == OP_CLEAR) begin
      rd_total_next = '0;
      wr_total_next = '0;
    end else if (req.sym != req.stale) begin
      // the departing symbol leaves its total, never below zero
      if (req.stale == SYM_READ) begin
        if (rd_total_next != '0) rd_total_next = rd_total_next - 1'b1;
      end else if (req.stale != SYM_NONE) begin
        if (wr_total_next != '0) wr_total_next = wr_total_next - 1'b1;
      end
      if (req.sym == SYM_READ) begin
        if (rd_total_next < TOTAL_MAX) rd_total_next = rd_total_next + 1'b1;
      end else if (req.sym != SYM_NONE) begin
        if (wr_total_next < TOTAL_MAX) wr_total_next = wr_total_next + 1'b1;
      end
    end
  end

  assign sum       = {1'b0, rd_total_next} + {1'b0, wr_total_next};
  assign none_next = (sum > {1'b0, width}) ? '0 : CW'({1'b0, width} - sum);

endmodule

// ===== rtl/sliding_window_symbol_counter.sv =====
// sliding window symbol counter: top level with window store and stream ports
// a request is registered in the write stage, then in the output register behind m_tvalid
// throughput: one request per cycle unless the output stalls, held by the read-modify-write
//   of the window store through one read and one write port, with write-stage forwarding
// reset and clear make no pass over the store: a wrap flag marks entries
//   not yet written since the last clear, which read as none
module sliding_window_symbol_counter #(
  parameter int WINDOW_MAX = swsc_pkg::WINDOW_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [swsc_pkg::CFG_W-1:0]      cfg_wdata,   // window_width
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [swsc_pkg::S_DATA_W-1:0]   s_tdata,     // [1:0] symbol
  input  logic [swsc_pkg::OP_W-1:0]       s_tuser,     // [0] opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [swsc_pkg::M_DATA_W-1:0]   m_tdata      // [10:0] count_read,
                                                       // [21:11] count_write,
                                                       // [32:22] count_none
);
  import swsc_pkg::*;

  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [CW-1:0] WIDTH_INIT =
    CW'((WIDTH_RESET > WINDOW_MAX) ? WINDOW_MAX : WIDTH_RESET);

  // window store
  logic [SYM_W-1:0] mem [WINDOW_MAX];
  logic [SYM_W-1:0] rd_data;
  logic             mem_we;

  // configuration and front state
  logic [CW-1:0] width;
  logic [PW-1:0] pos;
  logic          wrapped;
  logic [CW-1:0] pos_inc;

  // write stage
  logic             s1_valid;
  logic [OP_W-1:0]  s1_op;
  logic [SYM_W-1:0] s1_sym;
  logic [PW-1:0]    s1_addr;
  logic             s1_live;
  logic             fwd;
  logic [SYM_W-1:0] fwd_sym;
  logic             s1_go;

  logic [CW-1:0] read_total;
  logic [CW-1:0] write_total;
  logic [CW-1:0] rd_total_next;
  logic [CW-1:0] wr_total_next;
  logic [CW-1:0] none_next;

  logic             s_accept;
  logic [OP_W-1:0]  in_op;
  logic [SYM_W-1:0] in_sym;
  logic [SYM_W-1:0] stale_raw;
  tally_req_t       req;

  assign in_op    = s_tuser;
  assign in_sym   = (s_tdata[SYM_W-1:0] == SYM_INVALID) ? SYM_NONE : s_tdata[SYM_W-1:0];
  assign s1_go    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;
  assign s_accept = s_tvalid && s_tready;
  assign pos_inc  = CW'(pos) + 1'b1;
  assign mem_we   = s1_go && (s1_op == OP_ADVANCE);

  // configuration register; a write clears position, wrap flag, totals; a zero write is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WIDTH_INIT;
    end else if (cfg_we && (cfg_wdata != '0)) begin
      if (32'(cfg_wdata) > WINDOW_MAX) width <= CW'(WINDOW_MAX);
      else                             width <= CW'(cfg_wdata);
    end
  end

  // position and wrap flag move at acceptance, ahead of the store access
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_wdata != '0))) begin
      pos     <= '0;
      wrapped <= 1'b0;
    end else if (s_accept) begin
      if (in_op == OP_CLEAR) begin
        pos     <= '0;
        wrapped <= 1'b0;
      end else if (pos_inc >= width) begin
        pos     <= '0;
        wrapped <= 1'b1;
      end else begin
        pos <= PW'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[s1_addr] <= s1_sym;
    if (s_accept) rd_data <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_op   <= in_op;
      s1_sym  <= in_sym;
      s1_addr <= pos;
      s1_live <= wrapped;
      // the entry being written this cycle is the one being read
      fwd     <= mem_we && (s1_addr == pos);
      fwd_sym <= s1_sym;
    end
  end

  assign stale_raw = fwd ? fwd_sym : rd_data;
  assign req.op    = s1_op;
  assign req.sym   = s1_sym;
  assign req.stale = (!s1_live || (stale_raw == SYM_INVALID)) ? SYM_NONE : stale_raw;

  swsc_tally #(
    .WINDOW_MAX (WINDOW_MAX),
    .CW         (CW)
  ) u_tally (
    .req           (req),
    .rd_total      (read_total),
    .wr_total      (write_total),
    .width         (width),
    .rd_total_next (rd_total_next),
    .wr_total_next (wr_total_next),
    .none_next     (none_next)
  );

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_wdata != '0))) begin
      read_total  <= '0;
      write_total <= '0;
    end else if (s1_go) begin
      read_total  <= rd_total_next;
      write_total <= wr_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      m_tdata <= {(M_DATA_W - 3 * COUNT_W)'(0), COUNT_W'(none_next),
                  COUNT_W'(wr_total_next), COUNT_W'(rd_total_next)};
    end
  end

  // forwarding never arms when the write stage was empty at acceptance
  a_fwd_needs_stage: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !s1_valid) |=> !fwd)
    else $error("forward flag set with empty write stage");

  // totals stay within the window
  a_totals_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, read_total} + {1'b0, write_total}) <= {1'b0, width})
    else $error("read and write totals exceed window width");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(pos) < width)
    else $error("write position beyond window width");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_op == OP_CLEAR)) |=> (read_total == '0) && (write_total == '0))
    else $error("totals not zero after clear request");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled with empty write stage");

endmodule

// ===== tb/tb_sliding_window_symbol_counter.sv =====
// testbench for the sliding window symbol counter: directed and random requests against a predictor
module tb_sliding_window_symbol_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import swsc_pkg::*;

  localparam int WMAX              = WINDOW_MAX_DEF;
  localparam int SETTLE_CYCLES     = 4;
  localparam int LONG_STALL_CYCLES = 300;

  typedef struct packed {
    logic [COUNT_W-1:0] rd;
    logic [COUNT_W-1:0] wr;
    logic [COUNT_W-1:0] none;
  } window_counts_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic [OP_W-1:0]     s_tuser   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // predictor state
  logic [SYM_W-1:0] win_store [WMAX];
  int unsigned      win_pos;
  int unsigned      rd_total;
  int unsigned      wr_total;
  int unsigned      win_width = WMAX;
  window_counts_t   pending_counts [$];

  int   n_errors      = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic long_stall    = 1'b0;
  event long_stall_ev;

  sliding_window_symbol_counter #(
    .WINDOW_MAX(WMAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_window();
    foreach (win_store[i]) win_store[i] = SYM_NONE;
    win_pos  = 0;
    rd_total = 0;
    wr_total = 0;
  endfunction

  // zero is ignored, anything above the maximum saturates; a real write always clears
  function automatic void apply_width(logic [CFG_W-1:0] value);
    if (value != '0) begin
      win_width = (value > WMAX) ? WMAX : int'(value);
      clear_window();
    end
  endfunction

  function automatic window_counts_t predict_counts(logic [OP_W-1:0] op,
                                                    logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] fresh;
    logic [SYM_W-1:0] stale;
    window_counts_t   c;
    if (op == OP_CLEAR) begin
      clear_window();
    end else begin
      fresh = (sym == SYM_INVALID) ? SYM_NONE : sym;
      stale = win_store[win_pos];
      if (fresh != stale) begin
        win_store[win_pos] = fresh;
        if (stale == SYM_READ && rd_total > 0) rd_total--;
        if (stale == SYM_WRITE && wr_total > 0) wr_total--;
        if (fresh == SYM_READ && rd_total < WMAX) rd_total++;
        if (fresh == SYM_WRITE && wr_total < WMAX) wr_total++;
      end
      win_pos = (win_pos + 1 >= win_width) ? 0 : win_pos + 1;
    end
    c.rd   = COUNT_W'(rd_total);
    c.wr   = COUNT_W'(wr_total);
    c.none = COUNT_W'((rd_total + wr_total > win_width) ? 0 :
                      win_width - rd_total - wr_total);
    return c;
  endfunction

  always @(posedge clk) begin
    m_tready <= !long_stall && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  always begin
    @(long_stall_ev);
    long_stall <= 1'b1;
    repeat (LONG_STALL_CYCLES) @(posedge clk);
    long_stall <= 1'b0;
  end

  always @(posedge clk) begin
    window_counts_t exp_c;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_counts.size() == 0) begin
        $error("result with no request outstanding: m_tdata=%h", m_tdata);
        n_errors++;
      end else begin
        exp_c = pending_counts.pop_front();
        if (m_tdata[COUNT_W-1:0] !== exp_c.rd) begin
          $error("count_read expected %0d got %0d", exp_c.rd, m_tdata[COUNT_W-1:0]);
          n_errors++;
        end
        if (m_tdata[2*COUNT_W-1:COUNT_W] !== exp_c.wr) begin
          $error("count_write expected %0d got %0d", exp_c.wr,
                 m_tdata[2*COUNT_W-1:COUNT_W]);
          n_errors++;
        end
        if (m_tdata[3*COUNT_W-1:2*COUNT_W] !== exp_c.none) begin
          $error("count_none expected %0d got %0d", exp_c.none,
                 m_tdata[3*COUNT_W-1:2*COUNT_W]);
          n_errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W-SYM_W){1'b0}}, sym};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_counts.push_back(predict_counts(op, sym));
  endtask

  task automatic advance(input logic [SYM_W-1:0] sym);
    send_item(OP_ADVANCE, sym);
  endtask

  task automatic send_random_item(input int clear_pct);
    int               r;
    logic [SYM_W-1:0] sym;
    logic [OP_W-1:0]  op;
    r = $urandom_range(99);
    if (r < 40)      sym = SYM_READ;
    else if (r < 75) sym = SYM_WRITE;
    else if (r < 92) sym = SYM_NONE;
    else             sym = SYM_INVALID;
    op = ($urandom_range(99) < clear_pct) ? OP_CLEAR : OP_ADVANCE;
    send_item(op, sym);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_width(value);
    @(posedge clk);
  endtask

  // reset width, every symbol kind and a clear
  task automatic test_reset_window();
    advance(SYM_READ);
    advance(SYM_WRITE);
    advance(SYM_INVALID);
    advance(SYM_NONE);
    send_item(OP_CLEAR, SYM_WRITE);
    advance(SYM_READ);
    wait_drain();
  endtask

  // two-entry window: wrap, repeats of the stale symbol, replacements
  task automatic test_small_window();
    write_width(11'd2);
    advance(SYM_READ);
    advance(SYM_READ);
    advance(SYM_READ);
    advance(SYM_WRITE);
    send_item(OP_CLEAR, SYM_READ);
    advance(SYM_NONE);
    advance(SYM_WRITE);
    advance(SYM_WRITE);
    advance(SYM_INVALID);
    advance(SYM_READ);
    wait_drain();
  endtask

  // ignored zero write keeps the window, oversized write saturates, width of one
  task automatic test_width_writes();
    write_width(11'd0);
    advance(SYM_READ);
    wait_drain();
    write_width(11'h7FF);
    advance(SYM_WRITE);
    wait_drain();
    write_width(11'd1);
    advance(SYM_READ);
    advance(SYM_READ);
    advance(SYM_WRITE);
    advance(SYM_NONE);
    wait_drain();
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] width, input int idle_pct,
                           input int stall, input int n_items, input int clear_pct);
    wait_drain();
    write_width(width);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (n_items) send_random_item(clear_pct);
    wait_drain();
  endtask

  task automatic test_random_phases();
    run_phase(11'd3, 0, 0, 100, 2);
    run_phase(11'd17, 69, 0, 100, 2);
    run_phase(CFG_W'($urandom_range(4, 64)), 0, 69, 100, 2);
    run_phase(11'd682, 27, 27, 110, 2);
  endtask

  // oversized write lands on the full window, then enough requests to wrap it
  task automatic test_full_window_wrap();
    run_phase(11'd1365, 0, 0, 1060, 0);
  endtask

  // receiver holds off long enough to fill the block, sender then pauses for a drain
  task automatic test_output_backpressure();
    wait_drain();
    write_width(11'd5);
    send_idle_pct = 0;
    stall_pct     = 0;
    -> long_stall_ev;
    repeat (60) send_random_item(2);
    wait_drain();
    repeat (20) send_random_item(2);
    wait_drain();
  endtask

  initial begin
    clear_window();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_small_window();
    test_width_writes();
    test_random_phases();
    test_full_window_wrap();
    test_output_backpressure();
    wait_drain();
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_counts.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
